// File: rtl/pmt_pkg.sv
// ----------------------------------------------------------------------------
// Pulse meter totalizer package
// Shared widths, register indexes, controller states and the job record that
// travels from the decode front end to the division back end.
// ----------------------------------------------------------------------------
package pmt_pkg;

    localparam int BCD_W   = 24;   // three packed BCD bytes
    localparam int DEC_W   = 21;   // decoded count, at most 1666665
    localparam int ROLL_W  = 8;    // stored rollover byte
    localparam int ROLLX_W = 9;    // rollover count before the modulo-256 wrap
    localparam int DATA_W  = 32;   // readings, divisors, scaled counts
    localparam int IDX_W   = 2;    // configuration register index
    localparam int STEP_W  = $clog2(DATA_W);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Scaling constants: ten pulses per count, 999999 counts per rollover.
    localparam logic [DATA_W-1:0] SCALE_TEN  = 32'd10;
    localparam logic [DATA_W-1:0] ROLL_STEP  = 32'd9999990;
    localparam logic [DATA_W-1:0] DIV_ONE    = 32'd1;
    localparam logic [DATA_W-1:0] INIT_RESET = 32'd0;

    typedef enum logic [IDX_W-1:0] {
        REG_INIT_A = 2'd0,
        REG_DIV_A  = 2'd1,
        REG_INIT_B = 2'd2,
        REG_DIV_B  = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] scaled;
        logic [DATA_W-1:0] divisor;
        logic [DATA_W-1:0] init;
        logic [DEC_W-1:0]  cur;
        logic [DEC_W-1:0]  prev;
        logic [ROLL_W-1:0] new_roll;
        logic              wr_prev;
        logic              wr_roll;
    } t_job;

    // Queue status seen by the back end.
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_stat;

endpackage

// File: rtl/pmt_if.sv
// ----------------------------------------------------------------------------
// Pulse meter totalizer channel interfaces
// Valid/ready interfaces for the input words, the result words and the
// configuration writes.
// ----------------------------------------------------------------------------
interface pmt_in_if;
    logic                      valid;
    logic                      ready;
    logic                      channel;
    logic [pmt_pkg::BCD_W-1:0] current_bcd;
    logic [pmt_pkg::BCD_W-1:0] previous_bcd;
    logic [pmt_pkg::ROLL_W-1:0] rollover_count;

    modport source (output valid, channel, current_bcd, previous_bcd, rollover_count,
                    input ready);
    modport sink   (input valid, channel, current_bcd, previous_bcd, rollover_count,
                    output ready);
endinterface

interface pmt_out_if;
    logic                        valid;
    logic                        ready;
    logic [pmt_pkg::DATA_W-1:0]  meter_reading;
    logic [pmt_pkg::DEC_W-1:0]   current_decimal;
    logic [pmt_pkg::DEC_W-1:0]   previous_decimal;
    logic [pmt_pkg::ROLL_W-1:0]  new_rollover_count;
    logic                        write_previous;
    logic                        write_rollover;

    modport source (output valid, meter_reading, current_decimal, previous_decimal,
                           new_rollover_count, write_previous, write_rollover,
                    input ready);
    modport sink   (input valid, meter_reading, current_decimal, previous_decimal,
                          new_rollover_count, write_previous, write_rollover,
                    output ready);
endinterface

interface pmt_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [pmt_pkg::IDX_W-1:0]  index;
    logic [pmt_pkg::DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/pmt_front.sv
// ----------------------------------------------------------------------------
// Pulse meter totalizer front end
// Holds the configuration registers, decodes the BCD counts, classifies the
// word as advance, rollover or no change and builds the division job.
// ----------------------------------------------------------------------------
module pmt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pmt_in_if.sink              i_in,
    pmt_cfg_if.sink             i_cfg,
    input  pmt_pkg::t_q_stat    i_q_stat,
    output logic                o_push,
    output pmt_pkg::t_job       o_job
);
    import pmt_pkg::*;

    // One packed BCD byte pair to binary, nibbles taken at face value.
    function automatic logic [7:0] dec_pair(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'd0, b[7:4]};
        return {4'd0, b[3:0]} + ((hi << 3) + (hi << 1));
    endfunction

    function automatic logic [DEC_W-1:0] dec_bcd6(input logic [BCD_W-1:0] raw);
        logic [DEC_W-1:0] p0;
        logic [DEC_W-1:0] p1;
        logic [DEC_W-1:0] p2;
        p0 = DEC_W'(dec_pair(raw[7:0]));
        p1 = DEC_W'(dec_pair(raw[15:8]));
        p2 = DEC_W'(dec_pair(raw[23:16]));
        return p0 + DEC_W'(p1 * DEC_W'(100)) + DEC_W'(p2 * DEC_W'(10000));
    endfunction

    logic [DATA_W-1:0] r_init_a;
    logic [DATA_W-1:0] r_div_a;
    logic [DATA_W-1:0] r_init_b;
    logic [DATA_W-1:0] r_div_b;

    logic               r_vld;
    logic [DEC_W-1:0]   r_cur;
    logic [DEC_W-1:0]   r_prev;
    logic [ROLLX_W-1:0] r_rolls;
    logic               r_wr_prev;
    logic               r_wr_roll;
    logic [DATA_W-1:0]  r_init;
    logic [DATA_W-1:0]  r_div;

    logic [DEC_W-1:0]   cur_dec;
    logic [DEC_W-1:0]   prev_dec;
    logic               advance;
    logic               rolled;
    logic               accept;
    logic               stage_free;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_a <= INIT_RESET;
            r_div_a  <= DIV_ONE;
            r_init_b <= INIT_RESET;
            r_div_b  <= DIV_ONE;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_INIT_A: r_init_a <= i_cfg.data;
                REG_DIV_A:  r_div_a  <= i_cfg.data;
                REG_INIT_B: r_init_b <= i_cfg.data;
                REG_DIV_B:  r_div_b  <= i_cfg.data;
                default:    r_init_a <= r_init_a;
            endcase
        end
    end

    assign cur_dec  = dec_bcd6(i_in.current_bcd);
    assign prev_dec = dec_bcd6(i_in.previous_bcd);
    assign advance  = cur_dec > prev_dec;
    assign rolled   = cur_dec < prev_dec;

    assign o_push     = r_vld && !i_q_stat.full;
    assign stage_free = !r_vld || !i_q_stat.full;
    assign i_in.ready = stage_free;
    assign accept     = i_in.valid && stage_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur     <= cur_dec;
            r_prev    <= prev_dec;
            r_rolls   <= {1'b0, i_in.rollover_count} + ROLLX_W'(rolled);
            r_wr_prev <= advance || rolled;
            r_wr_roll <= rolled;
            r_init    <= i_in.channel ? r_init_b : r_init_a;
            r_div     <= i_in.channel ? r_div_b  : r_div_a;
        end
    end

    // The unwrapped count stays below 2^32, so no term overflows.
    always_comb begin
        o_job.scaled   = (DATA_W'(r_cur) * SCALE_TEN) + (DATA_W'(r_rolls) * ROLL_STEP);
        o_job.divisor  = (r_div == '0) ? DIV_ONE : r_div;
        o_job.init     = r_init;
        o_job.cur      = r_cur;
        o_job.prev     = r_prev;
        o_job.new_roll = r_rolls[ROLL_W-1:0];
        o_job.wr_prev  = r_wr_prev;
        o_job.wr_roll  = r_wr_roll;
    end

endmodule

// File: rtl/pmt_queue.sv
// ----------------------------------------------------------------------------
// Pulse meter totalizer job queue
// Two-entry first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module pmt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pmt_pkg::t_job    i_job,
    input  logic             i_pop,
    output pmt_pkg::t_job    o_job,
    output pmt_pkg::t_q_stat o_stat
);
    import pmt_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.not_empty = r_count != '0;
    assign o_stat.full      = r_count == Q_CNT_W'(Q_DEPTH);
    assign do_push          = i_push && !o_stat.full;
    assign do_pop           = i_pop && o_stat.not_empty;
    assign o_job            = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/pmt_back.sv
// ----------------------------------------------------------------------------
// Pulse meter totalizer back end
// Restoring radix-2 divider, one quotient bit per cycle, followed by the
// offset add and the result register.
// ----------------------------------------------------------------------------
module pmt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pmt_pkg::t_q_stat i_q_stat,
    input  pmt_pkg::t_job    i_job,
    output logic             o_pop,
    pmt_out_if.source        o_out
);
    import pmt_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [STEP_W-1:0] r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    t_job              r_job;

    logic              r_o_valid;
    logic [DATA_W-1:0] r_o_reading;
    logic [DEC_W-1:0]  r_o_cur;
    logic [DEC_W-1:0]  r_o_prev;
    logic [ROLL_W-1:0] r_o_roll;
    logic              r_o_wp;
    logic              r_o_wr;

    logic              out_free;
    logic              load_out;
    logic [DATA_W:0]   trial;
    logic [DATA_W+1:0] diff;

    assign out_free = !r_o_valid || o_out.ready;
    assign trial    = {r_rem, r_quo[DATA_W-1]};
    assign diff     = {1'b0, trial} - {2'b00, r_dvs};

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_stat.not_empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_cnt == STEP_W'(DATA_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (i_q_stat.not_empty) begin
                        o_pop   = 1'b1;
                        n_state = ST_RUN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_pop) begin
            r_cnt <= '0;
        end else if (r_state == ST_RUN) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_quo <= i_job.scaled;
            r_rem <= '0;
            r_dvs <= i_job.divisor;
        end else if (r_state == ST_RUN) begin
            if (!diff[DATA_W+1]) begin
                r_rem <= diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_reading <= r_job.init + r_quo;
            r_o_cur     <= r_job.cur;
            r_o_prev    <= r_job.prev;
            r_o_roll    <= r_job.new_roll;
            r_o_wp      <= r_job.wr_prev;
            r_o_wr      <= r_job.wr_roll;
        end
    end

    assign o_out.valid              = r_o_valid;
    assign o_out.meter_reading      = r_o_reading;
    assign o_out.current_decimal    = r_o_cur;
    assign o_out.previous_decimal   = r_o_prev;
    assign o_out.new_rollover_count = r_o_roll;
    assign o_out.write_previous     = r_o_wp;
    assign o_out.write_rollover     = r_o_wr;

endmodule

// File: rtl/pulse_meter_totalizer_top.sv
// ----------------------------------------------------------------------------
// Pulse meter totalizer
// Turns a pair of packed BCD counter readings into a scaled meter total and
// the write-back flags for the stored previous count and rollover byte.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one word per reading: channel select, current and
// previous BCD counts and the stored rollover byte. The result channel gives
// one word per input word, in order, with the total reading, both decoded
// counts, the rollover byte to store back and two write flags.
// The configuration channel is always ready; it writes the offset and the
// divisor of channel A or B and should only be used while no word is in
// flight.
// A result word passes through the front-end stage, the queue, the divider
// and the result register. Both channels share the single radix-2 divider,
// which resolves one quotient bit per cycle while it runs, followed by the
// offset add into the result register.
// The front end keeps accepting words while the divider is busy, until its
// stage and the two-entry queue are full. A stalled receiver holds the
// result register; the divider finishes its current word and waits there.
// Reset clears all handshakes and queue state, sets both offsets to zero
// and both divisors to one.
// ----------------------------------------------------------------------------
module pulse_meter_totalizer_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pmt_in_if.sink    i_in,
    pmt_cfg_if.sink   i_cfg,
    pmt_out_if.source o_out
);
    import pmt_pkg::*;

    // Front end to queue.
    logic    push;
    t_job    front_job;

    // Queue to back end.
    logic    pop;
    t_job    q_job;
    t_q_stat q_stat;

    pmt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (front_job)
    );

    pmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    pmt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_job    (q_job),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule
